FILE: sv/r5spe_pkg.sv
// Shared types and constants for the RAID-5 stripe parity encoder.
// Holds the request and response beat structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package r5spe_pkg;

   localparam int DISKS           = 4;
   localparam int BYTE_W          = 8;
   localparam int CSR_W           = 13;
   localparam int PDISK_W         = 2;
   localparam int STRIPE_W        = 16;
   localparam int OFFSET_W        = 12;
   localparam int BLK_W           = 2;
   localparam int MAX_BLOCK_DEF   = 4096;

   localparam logic [CSR_W-1:0] BLOCK_SIZE_RESET = 13'd4096;

   // Position of the current block within its stripe
   localparam logic [BLK_W-1:0] BLK_FIRST  = 2'd0;
   localparam logic [BLK_W-1:0] BLK_SECOND = 2'd1;
   localparam logic [BLK_W-1:0] BLK_THIRD  = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              start_of_file;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   disk0_byte;
      logic [BYTE_W-1:0]   disk1_byte;
      logic [BYTE_W-1:0]   disk2_byte;
      logic [BYTE_W-1:0]   disk3_byte;
      logic [PDISK_W-1:0]  parity_disk;
      logic [STRIPE_W-1:0] stripe_in_file;
      logic [OFFSET_W-1:0] byte_offset;
      logic                last_of_stripe;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/raid5_stripe_parity_encoder.sv
// Top level of the RAID-5 stripe parity encoder: two block buffers, stripe
// counters, parity stage and output register. Depends on r5spe_pkg.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   req_data  (r5spe_pkg::req_type)
//  rsp      out        rsp_valid/rsp_ready   rsp_data  (r5spe_pkg::rsp_type)
//  csr      in         csr_wr_en             csr_wr_data (block_size, 13 bits)
//
// One byte is taken per cycle while rsp is not stalled; the single buffer
// read port per block sets this. A third-block byte passes through the read
// stage and then the output register before its result leaves.
// Reset is synchronous and clears the counters, block_size and the valid
// flags; the buffers are not cleared and need no clearing pass.
// A stalled rsp holds the output register; req_ready drops only when both
// the read stage and the output register are full and rsp is stalled.
`timescale 1ns / 1ps
`default_nettype none

module raid5_stripe_parity_encoder #(
   parameter int MAX_BLOCK_BYTES = r5spe_pkg::MAX_BLOCK_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire r5spe_pkg::req_type          req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output r5spe_pkg::rsp_type               rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [r5spe_pkg::CSR_W-1:0] csr_wr_data
);

   import r5spe_pkg::*;

   localparam int ADDR_W = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
   localparam int SIZE_W = ($clog2(MAX_BLOCK_BYTES + 1) > CSR_W) ?
                           $clog2(MAX_BLOCK_BYTES + 1) : CSR_W;

   // Configuration
   logic [CSR_W-1:0]    block_size_ff;

   // Stripe state
   logic [ADDR_W-1:0]   byte_pos_ff,   byte_pos_in;
   logic [BLK_W-1:0]    blk_ff,        blk_in;
   logic [PDISK_W-1:0]  rot_ff,        rot_in;
   logic [STRIPE_W-1:0] fsc_ff,        fsc_in;

   // Block buffers
   logic [BYTE_W-1:0]   buf0_mem [MAX_BLOCK_BYTES];
   logic [BYTE_W-1:0]   buf1_mem [MAX_BLOCK_BYTES];
   logic [BYTE_W-1:0]   rd0_ff, rd1_ff;

   // Read stage
   logic                s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]   s1_byte_ff;
   logic [PDISK_W-1:0]  s1_pdisk_ff;
   logic [STRIPE_W-1:0] s1_stripe_ff;
   logic [OFFSET_W-1:0] s1_off_ff;
   logic                s1_last_ff;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                in_beat, out_free, s1_move;
   logic [SIZE_W-1:0]   size, size_m1, pos_wide;
   logic [ADDR_W-1:0]   pos_cur, pos;
   logic [BLK_W-1:0]    blk_cur;
   logic [STRIPE_W-1:0] fsc_cur;
   logic                last;
   logic                wr0, wr1, rd_en;
   logic [BYTE_W-1:0]   par;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign in_beat   = req_valid && req_ready;

   // Effective block size: zero acts as one, clamp to the buffer depth
   always_comb begin
      size = SIZE_W'(block_size_ff);
      if (block_size_ff == '0) begin
         size = SIZE_W'(1);
      end
      if (size > SIZE_W'(MAX_BLOCK_BYTES)) begin
         size = SIZE_W'(MAX_BLOCK_BYTES);
      end
      size_m1 = size - SIZE_W'(1);
   end

   // Start of file restarts the stripe; rotation is kept
   always_comb begin
      pos_cur  = req_data.start_of_file ? '0 : byte_pos_ff;
      blk_cur  = req_data.start_of_file ? BLK_FIRST : blk_ff;
      fsc_cur  = req_data.start_of_file ? '0 : fsc_ff;
      pos_wide = SIZE_W'(pos_cur);
      last     = (pos_wide >= size_m1);
      pos      = (pos_wide >= size) ? ADDR_W'(size_m1) : pos_cur;
   end

   assign wr0   = in_beat && (blk_cur == BLK_FIRST);
   assign wr1   = in_beat && (blk_cur == BLK_SECOND);
   assign rd_en = in_beat && (blk_cur == BLK_THIRD);

   always_comb begin
      byte_pos_in = byte_pos_ff;
      blk_in      = blk_ff;
      rot_in      = rot_ff;
      fsc_in      = fsc_ff;
      if (in_beat) begin
         byte_pos_in = last ? '0 : pos_cur + ADDR_W'(1);
         fsc_in      = fsc_cur;
         unique case (blk_cur)
            BLK_FIRST, BLK_SECOND: begin
               blk_in = last ? blk_cur + BLK_W'(1) : blk_cur;
            end
            BLK_THIRD: begin
               blk_in = last ? BLK_FIRST : BLK_THIRD;
               if (last) begin
                  rot_in = rot_ff + PDISK_W'(1);
                  fsc_in = fsc_cur + STRIPE_W'(1);
               end
            end
            default: begin
               blk_in = BLK_FIRST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_SIZE_RESET;
         byte_pos_ff   <= '0;
         blk_ff        <= BLK_FIRST;
         rot_ff        <= '0;
         fsc_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            block_size_ff <= csr_wr_data;
         end
         byte_pos_ff <= byte_pos_in;
         blk_ff      <= blk_in;
         rot_ff      <= rot_in;
         fsc_ff      <= fsc_in;
      end
   end

   // A beat either writes one buffer or reads both, so a read never meets a
   // write in the same cycle; earlier writes are already in the array.
   always_ff @(posedge clock) begin
      if (wr0) begin
         buf0_mem[pos] <= req_data.data_byte;
      end
      if (rd_en) begin
         rd0_ff <= buf0_mem[pos];
      end
   end

   always_ff @(posedge clock) begin
      if (wr1) begin
         buf1_mem[pos] <= req_data.data_byte;
      end
      if (rd_en) begin
         rd1_ff <= buf1_mem[pos];
      end
   end

   // Read stage side information, held while rd0/rd1 hold
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_byte_ff   <= req_data.data_byte;
         s1_pdisk_ff  <= PDISK_W'(DISKS - 1) - rot_ff;
         s1_stripe_ff <= fsc_cur;
         s1_off_ff    <= OFFSET_W'(pos);
         s1_last_ff   <= last;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // Parity on its disk, data fills the others in ascending order
   always_comb begin
      par    = rd0_ff ^ rd1_ff ^ s1_byte_ff;
      rsp_in = rsp_ff;
      rsp_in.parity_disk    = s1_pdisk_ff;
      rsp_in.stripe_in_file = s1_stripe_ff;
      rsp_in.byte_offset    = s1_off_ff;
      rsp_in.last_of_stripe = s1_last_ff;
      unique case (s1_pdisk_ff)
         2'd0: begin
            rsp_in.disk0_byte = par;
            rsp_in.disk1_byte = rd0_ff;
            rsp_in.disk2_byte = rd1_ff;
            rsp_in.disk3_byte = s1_byte_ff;
         end
         2'd1: begin
            rsp_in.disk0_byte = rd0_ff;
            rsp_in.disk1_byte = par;
            rsp_in.disk2_byte = rd1_ff;
            rsp_in.disk3_byte = s1_byte_ff;
         end
         2'd2: begin
            rsp_in.disk0_byte = rd0_ff;
            rsp_in.disk1_byte = rd1_ff;
            rsp_in.disk2_byte = par;
            rsp_in.disk3_byte = s1_byte_ff;
         end
         default: begin
            rsp_in.disk0_byte = rd0_ff;
            rsp_in.disk1_byte = rd1_ff;
            rsp_in.disk2_byte = s1_byte_ff;
            rsp_in.disk3_byte = par;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_read_fills_stage: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_valid_ff)
      else $error("third-block beat did not reach the read stage");

   a_parity_balances: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.disk0_byte ^ rsp_ff.disk1_byte ^
                         rsp_ff.disk2_byte ^ rsp_ff.disk3_byte) == '0))
      else $error("disk bytes do not XOR to zero");

   a_rotation_steps: assert property (@(posedge clock) disable iff (reset)
      (rd_en && last) |=> (rot_ff == $past(rot_ff) + PDISK_W'(1)))
      else $error("rotation row did not advance after a stripe");

   a_block_in_range: assert property (@(posedge clock) disable iff (reset)
      blk_ff != 2'd3)
      else $error("block counter out of range");
`endif

endmodule

`default_nettype wire
